// ===== src/spindle_duty_ramp_controller_macros.svh =====
// Assertion macros for the spindle duty ramp controller.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SPINDLE_DUTY_RAMP_CONTROLLER_MACROS_SVH
`define SPINDLE_DUTY_RAMP_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SPDR_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SPDR_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SPDR_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg)
`define SPDR_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/spdr_pkg.sv =====
// Shared widths, codes and types for the spindle duty ramp controller.
// No dependencies; the other source files apart from the macro header use this package.
package spdr_pkg;

	localparam int DUTY_W     = 12;
	localparam int TICK_W     = 16;
	localparam int PHASE_W    = 3;
	localparam int MODE_W     = 2;
	localparam int DIR_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int unsigned VSS_LOW_MS_DEF  = 10;
	localparam int unsigned VSS_HIGH_MS_DEF = 1000;

	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd2;

	localparam logic [PHASE_W-1:0] PH_OFF  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_MIN  = 3'd1;
	localparam logic [PHASE_W-1:0] PH_MAX  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_HOLD = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DOWN = 3'd4;

	localparam logic [DIR_W-1:0] DIR_BAD   = 2'd3;
	localparam logic [DIR_W-1:0] RELAY_OFF = 2'd3;

	localparam logic [DUTY_W-1:0] DUTY_ONE  = 12'h001;
	localparam logic [DUTY_W-1:0] DUTY_FULL = 12'hFFF;
	localparam logic [TICK_W-1:0] TICK_ONE  = 16'h0001;

	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VSS_PERIOD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VSS_STEP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UP_STEP       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UP_INTERVAL   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_STEP     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_INTERVAL = 3'd7;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_min;
		logic [DUTY_W-1:0] duty_max;
		logic [TICK_W-1:0] vss_period;
		logic [DUTY_W-1:0] vss_step;
		logic [DUTY_W-1:0] up_step;
		logic [TICK_W-1:0] up_interval;
		logic [DUTY_W-1:0] down_step;
		logic [TICK_W-1:0] down_interval;
	} cfg_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty;
		logic [PHASE_W-1:0] phase;
		logic [TICK_W-1:0]  tick;
		logic               swing_down;
		logic               swing_on;
		logic [DIR_W-1:0]   relay;
	} state_t;

	typedef struct packed {
		logic [DUTY_W-1:0]  duty;
		logic               pwm_on;
		logic [DIR_W-1:0]   relay_bits;
		logic               running;
		logic [PHASE_W-1:0] phase;
		logic               refused;
	} res_t;

endpackage

// ===== src/spdr_if.sv =====
// Request and result channel interfaces for the spindle duty ramp controller.
// Depends on spdr_pkg for field widths.
interface spdr_in_if;
	logic                          valid;
	logic                          ready;
	logic [spdr_pkg::MODE_W-1:0]   mode;
	logic [spdr_pkg::DIR_W-1:0]    direction;

	modport source (output valid, output mode, output direction, input ready);
	modport sink (input valid, input mode, input direction, output ready);
endinterface

interface spdr_out_if;
	logic                          valid;
	logic                          ready;
	logic [spdr_pkg::DUTY_W-1:0]   duty;
	logic                          pwm_on;
	logic [spdr_pkg::DIR_W-1:0]    relay_bits;
	logic                          running;
	logic [spdr_pkg::PHASE_W-1:0]  phase;
	logic                          refused;

	modport source (output valid, output duty, output pwm_on, output relay_bits,
		output running, output phase, output refused, input ready);
	modport sink (input valid, input duty, input pwm_on, input relay_bits,
		input running, input phase, input refused, output ready);
endinterface

// ===== src/spdr_cfg.sv =====
// Configuration register bank: eight write-only registers with reset values.
// Depends on spdr_pkg.
module spdr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spdr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [spdr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output spdr_pkg::cfg_t                 cfg
);
	import spdr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_min      <= '0;
			cfg_q.duty_max      <= DUTY_FULL;
			cfg_q.vss_period    <= '0;
			cfg_q.vss_step      <= DUTY_ONE;
			cfg_q.up_step       <= DUTY_ONE;
			cfg_q.up_interval   <= TICK_ONE;
			cfg_q.down_step     <= DUTY_ONE;
			cfg_q.down_interval <= TICK_ONE;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DUTY_MIN:      cfg_q.duty_min      <= cfg_wdata[DUTY_W-1:0];
				REG_DUTY_MAX:      cfg_q.duty_max      <= cfg_wdata[DUTY_W-1:0];
				REG_VSS_PERIOD:    cfg_q.vss_period    <= cfg_wdata[TICK_W-1:0];
				REG_VSS_STEP:      cfg_q.vss_step      <= cfg_wdata[DUTY_W-1:0];
				REG_UP_STEP:       cfg_q.up_step       <= cfg_wdata[DUTY_W-1:0];
				REG_UP_INTERVAL:   cfg_q.up_interval   <= cfg_wdata[TICK_W-1:0];
				REG_DOWN_STEP:     cfg_q.down_step     <= cfg_wdata[DUTY_W-1:0];
				REG_DOWN_INTERVAL: cfg_q.down_interval <= cfg_wdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/spdr_step.sv =====
// Next-state and result logic for one request of the duty sequencer.
// Purely combinational; depends on spdr_pkg.
module spdr_step #(
	parameter int unsigned VSS_LOW_MS  = spdr_pkg::VSS_LOW_MS_DEF,
	parameter int unsigned VSS_HIGH_MS = spdr_pkg::VSS_HIGH_MS_DEF
) (
	input  spdr_pkg::cfg_t                 cfg,
	input  spdr_pkg::state_t               cur,
	input  logic [spdr_pkg::MODE_W-1:0]    mode,
	input  logic [spdr_pkg::DIR_W-1:0]     direction,
	output spdr_pkg::state_t               nxt,
	output spdr_pkg::res_t                 res
);
	import spdr_pkg::*;

	logic [DUTY_W-1:0] up1, down1, base, climb_min, climb_max, dn_duty;
	logic [DUTY_W-1:0] sw_dn, sw_up;
	logic [DUTY_W:0]   up_sum, sw_sum;
	logic [TICK_W-1:0] upi1, dni1, tick_inc;
	logic              vss_ok, up_done, dn_done, vss_done, sd_new, refused;
	state_t            rtm, rtmax, rdn;

	// zero up/down step or interval behaves as one
	assign up1   = (cfg.up_step == '0) ? DUTY_ONE : cfg.up_step;
	assign down1 = (cfg.down_step == '0) ? DUTY_ONE : cfg.down_step;
	assign upi1  = (cfg.up_interval == '0) ? TICK_ONE : cfg.up_interval;
	assign dni1  = (cfg.down_interval == '0) ? TICK_ONE : cfg.down_interval;

	// an open restarts from zero duty
	assign base      = (mode == MODE_OPEN) ? '0 : cur.duty;
	assign up_sum    = {1'b0, base} + {1'b0, up1};
	assign climb_min = (up_sum > {1'b0, cfg.duty_min}) ? cfg.duty_min : up_sum[DUTY_W-1:0];
	assign climb_max = (up_sum > {1'b0, cfg.duty_max}) ? cfg.duty_max : up_sum[DUTY_W-1:0];
	assign dn_duty   = (cur.duty > down1) ? cur.duty - down1 : '0;

	assign vss_ok = (cfg.vss_period > TICK_W'(VSS_LOW_MS)) &&
		(cfg.vss_period < TICK_W'(VSS_HIGH_MS));

	assign tick_inc = cur.tick + TICK_ONE;
	assign up_done  = tick_inc >= upi1;
	assign dn_done  = tick_inc >= dni1;
	assign vss_done = tick_inc >= cfg.vss_period;

	// swing turns at the limits, otherwise keeps its direction
	assign sd_new = (cur.duty >= cfg.duty_max) ? 1'b1 :
		(cur.duty <= cfg.duty_min) ? 1'b0 : cur.swing_down;
	assign sw_dn  = (cur.duty > cfg.vss_step) ? cur.duty - cfg.vss_step : '0;
	assign sw_sum = {1'b0, cur.duty} + {1'b0, cfg.vss_step};
	assign sw_up  = sw_sum[DUTY_W] ? DUTY_FULL : sw_sum[DUTY_W-1:0];

	// ramp towards duty_min, falling through to the next phase when there
	always_comb begin
		rtm            = cur;
		rtm.duty       = base;
		rtm.tick       = '0;
		rtm.swing_on   = 1'b0;
		rtm.swing_down = 1'b0;
		if (base < cfg.duty_min) begin
			rtm.duty  = climb_min;
			rtm.phase = PH_MIN;
		end else if (vss_ok) begin
			rtm.phase    = PH_HOLD;
			rtm.swing_on = 1'b1;
		end else if (base < cfg.duty_max) begin
			rtm.duty  = climb_max;
			rtm.phase = PH_MAX;
		end else begin
			rtm.phase = PH_HOLD;
		end
	end

	always_comb begin
		rtmax      = cur;
		rtmax.tick = '0;
		if (cur.duty < cfg.duty_max) begin
			rtmax.duty = climb_max;
		end else begin
			rtmax.phase    = PH_HOLD;
			rtmax.swing_on = 1'b0;
		end
	end

	always_comb begin
		rdn          = cur;
		rdn.phase    = PH_DOWN;
		rdn.swing_on = 1'b0;
		rdn.tick     = '0;
		if (cur.duty != '0) begin
			rdn.duty = dn_duty;
		end else begin
			rdn.phase = PH_OFF;
			rdn.relay = RELAY_OFF;
		end
	end

	always_comb begin
		nxt     = cur;
		refused = 1'b0;
		case (mode)
			MODE_TICK: begin
				case (cur.phase)
					PH_MIN: begin
						if (up_done) nxt = rtm;
						else nxt.tick = tick_inc;
					end
					PH_MAX: begin
						if (up_done) nxt = rtmax;
						else nxt.tick = tick_inc;
					end
					PH_HOLD: begin
						if (cur.swing_on) begin
							if (vss_done) begin
								nxt.tick       = '0;
								nxt.swing_down = sd_new;
								nxt.duty       = sd_new ? sw_dn : sw_up;
							end else begin
								nxt.tick = tick_inc;
							end
						end
					end
					PH_DOWN: begin
						if (dn_done) nxt = rdn;
						else nxt.tick = tick_inc;
					end
					default: ;
				endcase
			end
			MODE_OPEN: begin
				if (direction == DIR_BAD || cur.phase != PH_OFF) begin
					refused = 1'b1;
				end else begin
					nxt       = rtm;
					nxt.relay = direction;
				end
			end
			MODE_CLOSE: begin
				if (cur.phase != PH_OFF && cur.phase != PH_DOWN) nxt = rdn;
			end
			default: ;
		endcase
	end

	assign res.duty       = nxt.duty;
	assign res.pwm_on     = nxt.phase != PH_OFF;
	assign res.relay_bits = nxt.relay;
	assign res.running    = nxt.phase != PH_OFF;
	assign res.phase      = nxt.phase;
	assign res.refused    = refused;

endmodule

// ===== src/spindle_duty_ramp_controller.sv =====
// Top level of the spindle PWM duty sequencer: request register, step logic, result register.
// Depends on spdr_pkg, spdr_if, spdr_cfg, spdr_step and the assertion macro header.
`include "spindle_duty_ramp_controller_macros.svh"
// Usage
// - in_ch carries one request per event: mode 0 is a millisecond tick, 1 opens the
//   spindle with a relay direction, 2 closes it. Each request yields exactly one
//   result on out_ch: duty, PWM enable, relay levels, running flag, phase and
//   whether an open was refused.
// - Config registers are written through cfg_we/cfg_idx/cfg_wdata, one per cycle,
//   and must only change while no request is in flight.
// - A request taken from in_ch is held in the request register, evaluated by the
//   step logic and registered as a valid result once the result stage can advance.
// - Throughput: one request per cycle while out_ch is not stalled. The sequencer
//   state feeds back through a single step of compare/add logic, so each request
//   sees the state left by the one before it.
// - A stalled out_ch keeps its result; the request register still takes one more
//   request, after which in_ch.ready drops until the result is taken.
// - Reset (arst_n low) empties both stages, loads the register defaults and puts
//   the spindle in the off phase: duty 0, relays both high.
module spindle_duty_ramp_controller #(
	parameter int unsigned VSS_LOW_MS  = spdr_pkg::VSS_LOW_MS_DEF,
	parameter int unsigned VSS_HIGH_MS = spdr_pkg::VSS_HIGH_MS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [spdr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [spdr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	spdr_in_if.sink                        in_ch,
	spdr_out_if.source                     out_ch
);
	import spdr_pkg::*;

	cfg_t              cfg;
	state_t            state_q, nxt_state;
	res_t              nxt_res, res_s2;
	logic              v_s1, v_s2, adv2, adv_s1, in_acc;
	logic [MODE_W-1:0] mode_s1;
	logic [DIR_W-1:0]  dir_s1;

	spdr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	spdr_step #(
		.VSS_LOW_MS  (VSS_LOW_MS),
		.VSS_HIGH_MS (VSS_HIGH_MS)
	) u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.mode      (mode_s1),
		.direction (dir_s1),
		.nxt       (nxt_state),
		.res       (nxt_res)
	);

	assign adv2        = !v_s2 || out_ch.ready;
	assign adv_s1      = v_s1 && adv2;
	assign in_ch.ready = !v_s1 || adv2;
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_acc) v_s1 <= 1'b1;
			else if (adv_s1) v_s1 <= 1'b0;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_s1 <= in_ch.mode;
			dir_s1  <= in_ch.direction;
		end
		if (adv_s1) res_s2 <= nxt_res;
	end

	// sequencer state moves only when its request is handed to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.duty       <= '0;
			state_q.phase      <= PH_OFF;
			state_q.tick       <= '0;
			state_q.swing_down <= 1'b0;
			state_q.swing_on   <= 1'b0;
			state_q.relay      <= RELAY_OFF;
		end else if (adv_s1) begin
			state_q <= nxt_state;
		end
	end

	assign out_ch.valid      = v_s2;
	assign out_ch.duty       = res_s2.duty;
	assign out_ch.pwm_on     = res_s2.pwm_on;
	assign out_ch.relay_bits = res_s2.relay_bits;
	assign out_ch.running    = res_s2.running;
	assign out_ch.phase      = res_s2.phase;
	assign out_ch.refused    = res_s2.refused;

	`SPDR_ASSERT_IMP(a_off_relays, clk, arst_n, (state_q.phase == PH_OFF), (state_q.relay == RELAY_OFF), "relays driven while spindle off")
	`SPDR_ASSERT_IMP(a_swing_hold, clk, arst_n, state_q.swing_on, (state_q.phase == PH_HOLD), "swing active outside hold phase")
	`SPDR_ASSERT_NXT(a_refused_keep, clk, arst_n, (adv_s1 && nxt_res.refused), ($stable(state_q.phase) && $stable(state_q.duty)), "refused open changed state")

endmodule
